>>> hw/rtl/gn3d_pkg.sv
`timescale 1ns / 1ps
package gn3d_pkg;

  localparam int FracBitsDef = 16;
  localparam int LatticeMaskDef = 255;
  localparam int OutFrac = 16;
  localparam int OutW = 18;

  localparam logic [7:0] PERM_ROM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,
    8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,8'd21,8'd10,
    8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,
    8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
    8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,
    8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
    8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,
    8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
    8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,
    8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,
    8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,
    8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
    8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,
    8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,
    8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,
    8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
    8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,
    8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
    8'd215,8'd61,8'd156,8'd180
  };

  localparam logic [3:0] HashDupA = 4'd12;
  localparam logic [3:0] HashDupB = 4'd14;

  function automatic logic [7:0] perm(input logic [7:0] i);
    return PERM_ROM[i];
  endfunction

endpackage

>>> hw/rtl/gn3d_fade.sv
`timescale 1ns / 1ps
// Fade curve over four register stages: the first forms 6t^2 - 15t + 10, each later stage multiplies by t once.
module gn3d_fade
  import gn3d_pkg::*;
#(
  parameter int FracBits = FracBitsDef
) (
  input  logic                clk_i,
  input  logic [FracBits-1:0] t_i,
  output logic [FracBits:0]   w_o
);
  localparam int QW = 2 * FracBits + 5;
  localparam int PW = QW + FracBits + 1;
  localparam logic signed [QW-1:0] One2 = QW'(1) <<< (2 * FracBits);
  localparam logic signed [PW-1:0] Half = PW'(1) <<< (FracBits - 1);

  logic signed [QW-1:0] q_d;
  logic signed [QW-FracBits-1:0] w0_q;
  logic signed [FracBits+5:0] w1_q, w2_q;
  logic [FracBits:0] w3_q;
  logic [FracBits-1:0] t0_q, t1_q, t2_q;
  logic signed [PW-1:0] p1, p2, p3, r1, r2, r3;
  logic signed [FracBits+1:0] ts0, ts1, ts2;
  logic signed [QW-1:0] tsq;

  assign tsq = QW'(signed'({1'b0, t_i}));
  assign q_d = 6 * tsq * tsq - ((15 * tsq) <<< FracBits) + 10 * One2;
  assign ts0 = signed'({2'b0, t0_q});
  assign ts1 = signed'({2'b0, t1_q});
  assign ts2 = signed'({2'b0, t2_q});
  assign p1 = PW'(w0_q) * PW'(ts0) + Half;
  assign p2 = PW'(w1_q) * PW'(ts1) + Half;
  assign p3 = PW'(w2_q) * PW'(ts2) + Half;
  assign r1 = p1 >>> FracBits;
  assign r2 = p2 >>> FracBits;
  assign r3 = p3 >>> FracBits;

  always_ff @(posedge clk_i) begin
    w0_q <= (QW-FracBits)'(((q_d + (QW'(1) <<< (FracBits - 1))) >>> FracBits));
    t0_q <= t_i;
    w1_q <= (FracBits+6)'(r1);
    t1_q <= t0_q;
    w2_q <= (FracBits+6)'(r2);
    t2_q <= t1_q;
    if (r3 < 0) begin
      w3_q <= '0;
    end else if (r3 > (PW'(1) <<< FracBits)) begin
      w3_q <= (FracBits+1)'(1) << FracBits;
    end else begin
      w3_q <= (FracBits+1)'(r3);
    end
  end

  assign w_o = w3_q;
endmodule

>>> hw/rtl/gn3d_grad.sv
`timescale 1ns / 1ps
// Gradient dot product of one corner; purely combinational selection.
module gn3d_grad
  import gn3d_pkg::*;
#(
  parameter int FracBits = FracBitsDef
) (
  input  logic [3:0]               hash_i,
  input  logic signed [FracBits+1:0] x_i,
  input  logic signed [FracBits+1:0] y_i,
  input  logic signed [FracBits+1:0] z_i,
  output logic signed [FracBits+3:0] g_o
);
  logic signed [FracBits+1:0] a, b;
  logic signed [FracBits+3:0] ae, be;

  always_comb begin
    a = (hash_i < 4'd8) ? x_i : y_i;
    if (hash_i < 4'd4) begin
      b = y_i;
    end else if (hash_i == HashDupA || hash_i == HashDupB) begin
      b = x_i;
    end else begin
      b = z_i;
    end
    ae = (FracBits+4)'(a);
    be = (FracBits+4)'(b);
    g_o = (hash_i[0] ? -ae : ae) + (hash_i[1] ? -be : be);
  end
endmodule

>>> hw/rtl/gn3d_lerp.sv
`timescale 1ns / 1ps
// Registered linear blend a + round(t * (b - a)).
module gn3d_lerp
  import gn3d_pkg::*;
#(
  parameter int FracBits = FracBitsDef,
  parameter int DataW    = FracBits + 4
) (
  input  logic                     clk_i,
  input  logic [FracBits:0]        t_i,
  input  logic signed [DataW-1:0]  a_i,
  input  logic signed [DataW-1:0]  b_i,
  output logic signed [DataW-1:0]  r_o
);
  localparam int PW = DataW + FracBits + 3;
  logic signed [PW-1:0] p;

  assign p = ((PW'(b_i) - PW'(a_i)) * PW'(signed'({1'b0, t_i})))
             + (PW'(1) <<< (FracBits - 1));

  always_ff @(posedge clk_i) begin
    r_o <= a_i + DataW'(p >>> FracBits);
  end
endmodule

>>> hw/rtl/gradient_noise_3d.sv
`timescale 1ns / 1ps
// Each accepted start yields one strobe of its result on valid_o.
// Throughput: one point per cycle; busy is held low, as every stage advances each cycle.
// The latency is set by the seven-stage pipeline: four fade and hash stages, three blend stages.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
// The receiver cannot stall, so each result is shown for exactly one cycle.
module gradient_noise_3d
  import gn3d_pkg::*;
#(
  parameter int FracBits = FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  output logic               valid_o,
  output logic signed [OutW-1:0] noise_value_o
);
  localparam int Lat = 7;
  localparam int DW = FracBits + 4;
  localparam int FW = FracBits + 2;

  logic [Lat-1:0] vld_q;
  logic [7:0] cx, cy, cz;
  logic [FracBits-1:0] fx, fy, fz;
  logic [FracBits:0] u, v, w;

  assign busy = 1'b0;
  assign cx = coord_x_i[FracBits +: 8];
  assign cy = coord_y_i[FracBits +: 8];
  assign cz = coord_z_i[FracBits +: 8];
  assign fx = coord_x_i[FracBits-1:0];
  assign fy = coord_y_i[FracBits-1:0];
  assign fz = coord_z_i[FracBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start};
    end
  end

  gn3d_fade #(.FracBits(FracBits)) u_fade_x (.clk_i, .t_i(fx), .w_o(u));
  gn3d_fade #(.FracBits(FracBits)) u_fade_y (.clk_i, .t_i(fy), .w_o(v));
  gn3d_fade #(.FracBits(FracBits)) u_fade_z (.clk_i, .t_i(fz), .w_o(w));

  // Hash chain, one permutation lookup level per stage.
  logic [7:0] a1_q, b1_q, y1_q, z1_q;
  logic [7:0] aa2_q, ab2_q, ba2_q, bb2_q;
  logic [3:0] h3_q [8];
  logic [FracBits-1:0] fx_q [3], fy_q [3], fz_q [3];

  always_ff @(posedge clk_i) begin
    a1_q  <= perm(cx);
    b1_q  <= perm(cx + 8'd1);
    y1_q  <= cy;
    z1_q  <= cz;
    aa2_q <= perm(a1_q + y1_q) + z1_q;
    ab2_q <= perm(a1_q + y1_q + 8'd1) + z1_q;
    ba2_q <= perm(b1_q + y1_q) + z1_q;
    bb2_q <= perm(b1_q + y1_q + 8'd1) + z1_q;
    h3_q[0] <= 4'(perm(aa2_q));
    h3_q[1] <= 4'(perm(ba2_q));
    h3_q[2] <= 4'(perm(ab2_q));
    h3_q[3] <= 4'(perm(bb2_q));
    h3_q[4] <= 4'(perm(aa2_q + 8'd1));
    h3_q[5] <= 4'(perm(ba2_q + 8'd1));
    h3_q[6] <= 4'(perm(ab2_q + 8'd1));
    h3_q[7] <= 4'(perm(bb2_q + 8'd1));
    fx_q[0] <= fx; fy_q[0] <= fy; fz_q[0] <= fz;
    for (int i = 1; i < 3; i++) begin
      fx_q[i] <= fx_q[i-1]; fy_q[i] <= fy_q[i-1]; fz_q[i] <= fz_q[i-1];
    end
  end

  // Stage 4: corner gradients registered, aligned with the fade outputs.
  logic signed [FW-1:0] x0, y0, z0, x1, y1, z1;
  logic signed [DW-1:0] g_d [8];
  logic signed [DW-1:0] g_q [8];
  logic [FracBits:0] v5_q, w5_q, w6_q;

  assign x0 = FW'(signed'({1'b0, fx_q[2]}));
  assign y0 = FW'(signed'({1'b0, fy_q[2]}));
  assign z0 = FW'(signed'({1'b0, fz_q[2]}));
  assign x1 = x0 - (FW'(1) <<< FracBits);
  assign y1 = y0 - (FW'(1) <<< FracBits);
  assign z1 = z0 - (FW'(1) <<< FracBits);

  for (genvar c = 0; c < 8; c++) begin : g_corner
    gn3d_grad #(.FracBits(FracBits)) u_grad (
      .hash_i(h3_q[c]),
      .x_i(((c & 1) != 0) ? x1 : x0),
      .y_i(((c & 2) != 0) ? y1 : y0),
      .z_i(((c & 4) != 0) ? z1 : z0),
      .g_o(g_d[c])
    );
  end

  always_ff @(posedge clk_i) begin
    g_q <= g_d;
    v5_q <= v;
    w5_q <= w;
    w6_q <= w5_q;
  end

  // Stages 5 to 7: blend along x, then y, then z.
  logic signed [DW-1:0] lx [4];
  logic signed [DW-1:0] ly [2];
  logic signed [DW-1:0] lz;

  for (genvar k = 0; k < 4; k++) begin : g_lx
    gn3d_lerp #(.FracBits(FracBits), .DataW(DW)) u_lerp (
      .clk_i, .t_i(u), .a_i(g_q[2*k]), .b_i(g_q[2*k+1]), .r_o(lx[k]));
  end
  for (genvar k = 0; k < 2; k++) begin : g_ly
    gn3d_lerp #(.FracBits(FracBits), .DataW(DW)) u_lerp (
      .clk_i, .t_i(v5_q), .a_i(lx[2*k]), .b_i(lx[2*k+1]), .r_o(ly[k]));
  end
  gn3d_lerp #(.FracBits(FracBits), .DataW(DW)) u_lerp_z (
    .clk_i, .t_i(w6_q), .a_i(ly[0]), .b_i(ly[1]), .r_o(lz));

  // Rescale to the output format and saturate.
  localparam int SW = DW + 17;
  logic signed [SW-1:0] n;
  always_comb begin
    if (FracBits > OutFrac) begin
      n = (SW'(lz) + (SW'(1) <<< (FracBits - OutFrac - 1))) >>> (FracBits - OutFrac);
    end else begin
      n = SW'(lz) <<< (OutFrac - FracBits);
    end
    if (n > SW'(131071)) begin
      noise_value_o = OutW'(131071);
    end else if (n < -SW'(131072)) begin
      noise_value_o = OutW'(-131072);
    end else begin
      noise_value_o = OutW'(n);
    end
  end

  assign valid_o = vld_q[Lat-1];

  // Each start yields a result strobe, the valid chain shifts intact, and the fade weight is at most one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(start, Lat) && $past(rst_ni, Lat) |-> valid_o)
    else $error("result strobe missing");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(vld_q[Lat-2]))
    else $error("valid chain broken");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] |-> u <= ((FracBits+1)'(1) << FracBits))
    else $error("fade weight above one");
endmodule

>>> verif/gradient_noise_3d_test.sv
`timescale 1ns / 1ps
module gradient_noise_3d_test;
  import gn3d_pkg::*;

  localparam int FracBits = FracBitsDef;
  localparam int Latency = 7;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] coord_x_i = '0;
  logic signed [31:0] coord_y_i = '0;
  logic signed [31:0] coord_z_i = '0;
  logic valid_o;
  logic signed [OutW-1:0] noise_value_o;

  gradient_noise_3d uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .coord_x_i(coord_x_i), .coord_y_i(coord_y_i), .coord_z_i(coord_z_i),
    .valid_o(valid_o), .noise_value_o(noise_value_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  point_t pending_points[$];
  logic signed [OutW-1:0] expected_noise[$];
  int unsigned gap_left = 0;
  bit hold_until_drained = 1'b0;
  bit stimulus_done = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;

  // Rounded right shift, ties toward plus infinity.
  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint fade_weight(longint t);
    longint one, q, w;
    one = longint'(1) << FracBits;
    q = 6 * t * t - 15 * t * one + 10 * one * one;
    w = round_shift(q, FracBits);
    w = round_shift(w * t, FracBits);
    w = round_shift(w * t, FracBits);
    w = round_shift(w * t, FracBits);
    if (w < 0) w = 0;
    if (w > one) w = one;
    return w;
  endfunction

  function automatic logic [7:0] lattice_hash(logic [7:0] i);
    return PERM_ROM[i];
  endfunction

  function automatic longint corner_dot(logic [7:0] hash, longint x, longint y, longint z);
    logic [3:0] h;
    longint a, b;
    h = hash[3:0];
    a = (h < 8) ? x : y;
    b = (h < 4) ? y : ((h == HashDupA || h == HashDupB) ? x : z);
    return (h[0] ? -a : a) + (h[1] ? -b : b);
  endfunction

  function automatic longint blend(longint t, longint a, longint b);
    return a + round_shift(t * (b - a), FracBits);
  endfunction

  function automatic logic signed [OutW-1:0] noise_at(point_t p);
    logic [7:0] cx, cy, cz, a, aa, ab, b, ba, bb;
    longint one, x, y, z, x1, y1, z1, u, v, w, n0, n1, n;
    one = longint'(1) << FracBits;
    cx = p.x[FracBits +: 8];
    cy = p.y[FracBits +: 8];
    cz = p.z[FracBits +: 8];
    x = longint'(p.x[FracBits-1:0]);
    y = longint'(p.y[FracBits-1:0]);
    z = longint'(p.z[FracBits-1:0]);
    x1 = x - one; y1 = y - one; z1 = z - one;
    u = fade_weight(x); v = fade_weight(y); w = fade_weight(z);
    a = lattice_hash(cx) + cy;
    aa = lattice_hash(a) + cz;
    ab = lattice_hash(a + 8'd1) + cz;
    b = lattice_hash(cx + 8'd1) + cy;
    ba = lattice_hash(b) + cz;
    bb = lattice_hash(b + 8'd1) + cz;
    n0 = blend(v,
      blend(u, corner_dot(lattice_hash(aa), x, y, z), corner_dot(lattice_hash(ba), x1, y, z)),
      blend(u, corner_dot(lattice_hash(ab), x, y1, z), corner_dot(lattice_hash(bb), x1, y1, z)));
    n1 = blend(v,
      blend(u, corner_dot(lattice_hash(aa + 8'd1), x, y, z1),
               corner_dot(lattice_hash(ba + 8'd1), x1, y, z1)),
      blend(u, corner_dot(lattice_hash(ab + 8'd1), x, y1, z1),
               corner_dot(lattice_hash(bb + 8'd1), x1, y1, z1)));
    n = blend(w, n0, n1);
    if (FracBits > OutFrac) n = round_shift(n, FracBits - OutFrac);
    else if (FracBits < OutFrac) n = n * (longint'(1) << (OutFrac - FracBits));
    if (n > 131071) n = 131071;
    if (n < -131072) n = -131072;
    return n[OutW-1:0];
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [31:0] random_coord();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom;
    if (r < 8) return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
    return {16'($urandom), (($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000)};
  endfunction

  // Driver: one transaction per accepted start.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_noise.push_back(noise_at(point_t'{coord_x_i, coord_y_i, coord_z_i}));
      end
      if (hold_until_drained && expected_noise.size() == 0 && !(start && !busy)) begin
        hold_until_drained <= 1'b0;
      end
      if (start && busy) begin
        // Item not yet taken; keep it presented.
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_points.size() > 0 && !hold_until_drained) begin
        point_t p;
        p = pending_points.pop_front();
        coord_x_i <= p.x;
        coord_y_i <= p.y;
        coord_z_i <= p.z;
        start <= 1'b1;
        gap_left <= pick_gap();
        if (pending_points.size() == 300) hold_until_drained <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobe must match the oldest expected sample.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (expected_noise.size() == 0) begin
        $error("noise_value: unexpected result %0d", noise_value_o);
        error_count++;
      end else begin
        logic signed [OutW-1:0] want;
        want = expected_noise.pop_front();
        if (noise_value_o !== want) begin
          $error("noise_value: expected %0d, actual %0d", want, noise_value_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] corner_vals[8];
    corner_vals = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                    32'h0000_FFFF, 32'hFFFF_0000, 32'h0001_8000, 32'hFF00_0001};
    for (int i = 0; i < 8; i++) begin
      pending_points.push_back(point_t'{corner_vals[i], corner_vals[(i + 3) % 8],
                                        corner_vals[(i + 5) % 8]});
    end
    // Points near lattice corners; x cell indices step by 21.
    for (int i = 0; i < 12; i++) begin
      pending_points.push_back(point_t'{{8'($urandom), 8'(i * 21), 16'h8000},
                                        {16'hFFFF - 16'(i), 16'hFFFF}, {16'(i), 16'h0001}});
    end
    for (int i = 0; i < 640; i++) begin
      pending_points.push_back(point_t'{random_coord(), random_coord(), random_coord()});
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_points.size() == 0 && !start);
    wait (expected_noise.size() == 0);
    repeat (Latency + 4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/gn3d_pkg.sv
hw/rtl/gn3d_fade.sv
hw/rtl/gn3d_grad.sv
hw/rtl/gn3d_lerp.sv
hw/rtl/gradient_noise_3d.sv
verif/gradient_noise_3d_test.sv
